FILE: rtl/core/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is held
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds across reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/core/tbdss_pkg.sv
// shared types, constants and helpers of the display serializer
package tbdss_pkg;

    // width of the byte on the input word
    localparam int BYTE_BITS   = 8;
    // data bits sent per byte on the serial line
    localparam int DATA_BITS   = 8;
    // register-select bit plus write bit
    localparam int HEADER_BITS = 2;
    localparam int FRAME_BITS  = DATA_BITS + HEADER_BITS;
    localparam int CNT_W       = $clog2(FRAME_BITS + 1);
    // read/write bit value for a write access
    localparam logic RW_WRITE  = 1'b0;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified byte waiting for the serializer
    typedef struct packed {
        logic [DATA_BITS-1:0] data;
        logic                 header;
        logic                 mode;
        logic                 last;
    } t_desc;

    // zero-extend or truncate a byte to the data bit count
    function automatic logic [DATA_BITS-1:0] fit_byte(input logic [BYTE_BITS-1:0] b);
        logic [DATA_BITS+BYTE_BITS-1:0] wide;
        wide = {{DATA_BITS{1'b0}}, b};
        return wide[DATA_BITS-1:0];
    endfunction

endpackage

FILE: rtl/core/tbdss_if.sv
// handshake interfaces for byte input words and serial bit output words
interface tbdss_in_if;
    import tbdss_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 is_data;
    logic                 last_byte;

    modport source (output valid, data_byte, is_data, last_byte, input ready);
    modport sink   (input valid, data_byte, is_data, last_byte, output ready);
endinterface

interface tbdss_out_if;
    logic valid;
    logic ready;
    logic serial_bit;
    logic select_active;
    logic last_of_byte;
    logic transfer_end;

    modport source (output valid, serial_bit, select_active, last_of_byte, transfer_end,
                    input ready);
    modport sink   (input valid, serial_bit, select_active, last_of_byte, transfer_end,
                    output ready);
endinterface

FILE: rtl/core/ten_bit_display_spi_serializer.sv
// top level: three-wire display serializer, front end, queue and bit shifter
// accepted bytes pass the queue and the shifter to the registered output bit
// throughput: one bit word per cycle from the back-end shifter unless the
//   output stalls; a byte is 10 bits with its rs/rw header, 8 without it
// reset: synchronous active low; clears the transfer state, the queue and
//   the output valid; the block takes words as soon as reset is released
module ten_bit_display_spi_serializer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbdss_in_if.sink    i_in,
    tbdss_out_if.source o_out
);
    import tbdss_pkg::*;

    logic  push_valid;
    logic  push_ready;
    t_desc push_desc;
    logic  pop_valid;
    logic  pop_ready;
    t_desc pop_desc;

    // classify words and track the open transfer
    tbdss_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_desc  (push_desc),
        .i_push_ready (push_ready)
    );

    // decoupling queue
    tbdss_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_desc  (push_desc),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_desc   (pop_desc),
        .i_pop_ready  (pop_ready)
    );

    // serial bit shifter with output register
    tbdss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_desc  (pop_desc),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule

FILE: rtl/core/tbdss_front.sv
// front end: tracks the transfer and decides which bytes carry a header
module tbdss_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tbdss_in_if.sink         i_in,
    output logic             o_push_valid,
    output tbdss_pkg::t_desc o_push_desc,
    input  logic             i_push_ready
);
    import tbdss_pkg::*;

    logic r_open, n_open;
    logic r_mode, n_mode;
    logic r_hdr_done, n_hdr_done;
    logic cur_mode;
    logic send_hdr;
    logic accept;

    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;
    assign accept       = i_in.valid && i_push_ready;

    // mode comes from the first word of a transfer, header is due unless already sent
    assign cur_mode = r_open ? r_mode : i_in.is_data;
    assign send_hdr = !(r_open && r_hdr_done);

    // classified word into the queue
    always_comb begin
        o_push_desc.data   = fit_byte(i_in.data_byte);
        o_push_desc.header = send_hdr;
        o_push_desc.mode   = cur_mode;
        o_push_desc.last   = i_in.last_byte;
    end

    // transfer state after an accepted word
    always_comb begin
        n_open     = r_open;
        n_mode     = r_mode;
        n_hdr_done = r_hdr_done;
        if (accept) begin
            if (i_in.last_byte) begin
                n_open     = 1'b0;
                n_mode     = 1'b0;
                n_hdr_done = 1'b0;
            end else begin
                n_open     = 1'b1;
                n_mode     = cur_mode;
                // data transfers send the header once, command transfers every byte
                n_hdr_done = cur_mode;
            end
        end
    end

    // transfer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_mode     <= 1'b0;
            r_hdr_done <= 1'b0;
        end else begin
            r_open     <= n_open;
            r_mode     <= n_mode;
            r_hdr_done <= n_hdr_done;
        end
    end

endmodule

FILE: rtl/core/tbdss_queue.sv
// small fifo that decouples the front end from the bit shifter
module tbdss_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  tbdss_pkg::t_desc i_push_desc,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output tbdss_pkg::t_desc o_pop_desc,
    input  logic             i_pop_ready
);
    import tbdss_pkg::*;

    t_desc             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_desc   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // pointer and fill level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_desc;
        end
    end

endmodule

FILE: rtl/core/tbdss_back.sv
// back end: shifts header and data bits out one per unstalled cycle
module tbdss_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pop_valid,
    input  tbdss_pkg::t_desc i_pop_desc,
    output logic             o_pop_ready,
    tbdss_out_if.source      o_out
);
    import tbdss_pkg::*;

    logic                  r_busy, n_busy;
    logic [FRAME_BITS-1:0] r_shift, n_shift;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_last, n_last;
    logic                  r_ov, n_ov;
    logic                  r_bit, n_bit;
    logic                  r_lob, n_lob;
    logic                  r_end, n_end;
    logic                  out_free;
    logic                  final_bit;
    logic                  pop;
    logic [FRAME_BITS-1:0] load_frame;
    logic [CNT_W-1:0]      load_cnt;

    assign out_free    = !r_ov || o_out.ready;
    assign final_bit   = (r_cnt == CNT_W'(1));
    // refill when idle or as the final bit of the current byte leaves
    assign o_pop_ready = !r_busy || (out_free && final_bit);
    assign pop         = i_pop_valid && o_pop_ready;

    // frame left-aligned: optional rs and rw bits, then data msb first
    always_comb begin
        if (i_pop_desc.header) begin
            load_frame = {i_pop_desc.mode, RW_WRITE, i_pop_desc.data};
            load_cnt   = CNT_W'(FRAME_BITS);
        end else begin
            load_frame = {i_pop_desc.data, {HEADER_BITS{1'b0}}};
            load_cnt   = CNT_W'(DATA_BITS);
        end
    end

    // shifter and output register next state
    always_comb begin
        n_busy  = r_busy;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_last  = r_last;
        n_ov    = r_ov;
        n_bit   = r_bit;
        n_lob   = r_lob;
        n_end   = r_end;
        if (out_free) begin
            n_ov = r_busy;
            if (r_busy) begin
                n_bit   = r_shift[FRAME_BITS-1];
                n_lob   = final_bit;
                n_end   = final_bit && r_last;
                n_shift = {r_shift[FRAME_BITS-2:0], 1'b0};
                n_cnt   = r_cnt - 1'b1;
                if (final_bit) begin
                    n_busy = 1'b0;
                end
            end
        end
        if (pop) begin
            n_busy  = 1'b1;
            n_shift = load_frame;
            n_cnt   = load_cnt;
            n_last  = i_pop_desc.last;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_ov   <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_cnt   <= n_cnt;
        r_last  <= n_last;
        r_bit   <= n_bit;
        r_lob   <= n_lob;
        r_end   <= n_end;
    end

    assign o_out.valid         = r_ov;
    assign o_out.serial_bit    = r_bit;
    assign o_out.select_active = 1'b1;
    assign o_out.last_of_byte  = r_lob;
    assign o_out.transfer_end  = r_end;

endmodule

FILE: rtl/core/tbdss_checker.sv
// port-level checks on the serializer output, bound to the top level
`include "assert_macros.svh"

module tbdss_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_serial_bit,
    input logic i_select_active,
    input logic i_last_of_byte,
    input logic i_transfer_end
);

    // no output word right after reset
    `ASSERT_ALWAYS(a_idle_after_reset, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // every emitted bit is sent with the device selected
    `ASSERT_RST(a_selected, i_out_valid |-> i_select_active, "bit sent while deselected")

    // transfer end is only flagged on the final bit of a byte
    `ASSERT_RST(a_end_on_byte_end, i_out_valid && i_transfer_end |-> i_last_of_byte, "transfer end mid byte")

    // a stalled bit word holds its value
    `ASSERT_RST(a_stall_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_serial_bit), "stalled bit changed")

endmodule

bind ten_bit_display_spi_serializer tbdss_checker u_tbdss_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_serial_bit    (o_out.serial_bit),
    .i_select_active (o_out.select_active),
    .i_last_of_byte  (o_out.last_of_byte),
    .i_transfer_end  (o_out.transfer_end)
);

FILE: tb/sv/tb_top.sv
// testbench for the three-wire display serializer: byte stimulus, bit prediction and checking
`timescale 1ns / 1ps

module tb_top;
    import tbdss_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_ITEMS = 114;
    localparam int CALM_TAIL = 20;
    localparam int SETTLE_CYCLES = 20;

    // one byte waiting for the driver, with an optional drain-first hold
    typedef struct packed {
        logic [BYTE_BITS-1:0] data;
        logic                 is_data;
        logic                 last;
        logic                 drain;
    } t_byte_item;

    // one serial bit word as it should leave the block
    typedef struct packed {
        logic serial_bit;
        logic select_active;
        logic last_of_byte;
        logic transfer_end;
    } t_bit_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tbdss_in_if  in_if ();
    tbdss_out_if out_if ();

    ten_bit_display_spi_serializer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // clock, 4 ns period
    always #2 i_clk = ~i_clk;

    t_byte_item pending_bytes[$];
    t_bit_word  expected_bits[$];

    // serializer state as the testbench tracks it
    logic xfer_open;
    logic xfer_mode;
    logic hdr_sent;

    int cycle_count;
    int mismatch_count;
    int bytes_taken;
    int bits_checked;
    int data_xfers;
    int cmd_xfers;
    int mid_mode_flips;
    logic word_accepted;
    int gap_left;
    int stall_left;
    int directed_count;

    // tail of the run goes without idling on either side
    function automatic logic calm_phase();
        return pending_bytes.size() < CALM_TAIL;
    endfunction

    function automatic void push_byte(input logic [BYTE_BITS-1:0] data, input logic is_data,
                                      input logic last);
        t_byte_item it;
        it.data = data;
        it.is_data = is_data;
        it.last = last;
        it.drain = 1'b0;
        pending_bytes.push_back(it);
    endfunction

    // expected bit words for one accepted byte: optional rs/rw header, then data msb first
    task automatic predict_byte_frame(input logic [BYTE_BITS-1:0] data, input logic is_data,
                                      input logic last);
        t_bit_word frame[$];
        t_bit_word w;
        if (!xfer_open) begin
            xfer_open = 1'b1;
            xfer_mode = is_data;
            hdr_sent = 1'b0;
            if (is_data) data_xfers++;
            else cmd_xfers++;
        end else if (is_data != xfer_mode) begin
            mid_mode_flips++;
        end
        w.select_active = 1'b1;
        w.last_of_byte = 1'b0;
        w.transfer_end = 1'b0;
        if (!hdr_sent) begin
            w.serial_bit = xfer_mode;
            frame.push_back(w);
            w.serial_bit = RW_WRITE;
            frame.push_back(w);
            if (xfer_mode) hdr_sent = 1'b1;
        end
        // bits above the byte width go out as zero
        for (int i = DATA_BITS - 1; i >= 0; i--) begin
            w.serial_bit = (i < BYTE_BITS) ? data[i] : 1'b0;
            frame.push_back(w);
        end
        frame[frame.size() - 1].last_of_byte = 1'b1;
        frame[frame.size() - 1].transfer_end = last;
        if (last) begin
            xfer_open = 1'b0;
            xfer_mode = 1'b0;
            hdr_sent = 1'b0;
        end
        foreach (frame[k]) expected_bits.push_back(frame[k]);
    endtask

    // input side: record the accepted word and predict its bits
    always @(posedge i_clk) begin
        word_accepted <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            predict_byte_frame(in_if.data_byte, in_if.is_data, in_if.last_byte);
            bytes_taken++;
            void'(pending_bytes.pop_front());
        end
    end

    // input driver: hold until taken, random gaps, drain holds
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (in_if.valid && !word_accepted) begin
            in_if.valid <= 1'b1;
        end else if (gap_left > 0) begin
            in_if.valid <= 1'b0;
            gap_left--;
        end else if (pending_bytes.size() == 0) begin
            in_if.valid <= 1'b0;
        end else if (pending_bytes[0].drain && expected_bits.size() != 0) begin
            in_if.valid <= 1'b0;
        end else if (!calm_phase() && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            gap_left = $urandom_range(0, 2);
        end else begin
            in_if.valid <= 1'b1;
            in_if.data_byte <= pending_bytes[0].data;
            in_if.is_data <= pending_bytes[0].is_data;
            in_if.last_byte <= pending_bytes[0].last;
        end
    end

    // output side: compare each bit word with the oldest expectation
    always @(posedge i_clk) begin
        t_bit_word got;
        t_bit_word want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.serial_bit = out_if.serial_bit;
            got.select_active = out_if.select_active;
            got.last_of_byte = out_if.last_of_byte;
            got.transfer_end = out_if.transfer_end;
            if (expected_bits.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] unexpected bit word: bit=%b sel=%b lob=%b end=%b",
                             $realtime, got.serial_bit, got.select_active,
                             got.last_of_byte, got.transfer_end);
            end else begin
                want = expected_bits.pop_front();
                bits_checked++;
                if (got.serial_bit !== want.serial_bit ||
                    got.select_active !== want.select_active ||
                    got.last_of_byte !== want.last_of_byte ||
                    got.transfer_end !== want.transfer_end) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] bit word %0d mismatch: exp bit=%b sel=%b lob=%b end=%b, got bit=%b sel=%b lob=%b end=%b",
                                 $realtime, bits_checked, want.serial_bit,
                                 want.select_active, want.last_of_byte, want.transfer_end,
                                 got.serial_bit, got.select_active, got.last_of_byte,
                                 got.transfer_end);
                end
            end
        end
    end

    // output ready: random stall bursts outside the calm tail
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left--;
        end else if (!calm_phase() && $urandom_range(0, 3) == 0) begin
            out_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bit words still expected",
                     cycle_count, expected_bits.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int len;
        logic mode;
        in_if.valid = 1'b0;
        in_if.data_byte = '0;
        in_if.is_data = 1'b0;
        in_if.last_byte = 1'b0;
        out_if.ready = 1'b0;
        xfer_open = 1'b0;
        xfer_mode = 1'b0;
        hdr_sent = 1'b0;
        word_accepted = 1'b0;
        gap_left = 0;
        stall_left = 0;
        cycle_count = 0;
        mismatch_count = 0;
        bytes_taken = 0;
        bits_checked = 0;
        data_xfers = 0;
        cmd_xfers = 0;
        mid_mode_flips = 0;

        // single-byte transfers at the byte extremes, both modes
        push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'hff, 1'b0, 1'b1);
        push_byte(8'h80, 1'b1, 1'b1);
        push_byte(8'h01, 1'b1, 1'b1);
        // command transfer, header repeats per byte; mode change ignored mid-transfer
        push_byte(8'ha5, 1'b0, 1'b0);
        push_byte(8'h5a, 1'b1, 1'b0);
        push_byte(8'h3c, 1'b0, 1'b1);
        // data transfer, header once; mode change ignored mid-transfer
        push_byte(8'hff, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h55, 1'b1, 1'b0);
        push_byte(8'haa, 1'b0, 1'b1);
        // back-to-back transfers of alternating mode
        push_byte(8'h7f, 1'b0, 1'b1);
        push_byte(8'hfe, 1'b1, 1'b0);
        push_byte(8'h81, 1'b1, 1'b1);
        push_byte(8'h0f, 1'b0, 1'b0);
        push_byte(8'hf0, 1'b0, 1'b1);
        directed_count = pending_bytes.size();

        // random transfers, mostly short, some long
        while (pending_bytes.size() < directed_count + RANDOM_ITEMS) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
            mode = 1'($urandom_range(0, 1));
            for (int k = 0; k < len; k++)
                push_byte(8'($urandom_range(0, 255)),
                          (k == 0) ? mode : 1'($urandom_range(0, 1)),
                          k == len - 1);
        end
        // sender waits for a full drain here and there
        pending_bytes[directed_count].drain = 1'b1;
        pending_bytes[directed_count + 60].drain = 1'b1;

        // hold reset, then release it on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0) @(posedge i_clk);
        while (expected_bits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (expected_bits.size() != 0) mismatch_count++;
        $display("%0d bytes sent in %0d command and %0d data transfers, %0d bit words checked",
                 bytes_taken, cmd_xfers, data_xfers, bits_checked);
        $display("%0d mid-transfer mode flips, %0d mismatches", mid_mode_flips, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
